@@ rtl/btrs_pkg.sv @@
`default_nettype none

package btrs_pkg;

	// Field and port widths.
	localparam int BARO_W = 24;
	localparam int HGT_W = 16;
	localparam int REF_W = 32;
	localparam int FIX_W = 11;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register map: word index taken from paddr[ADDR_W-1:2].
	localparam logic [ADDR_W-3:0] REG_BARO_FIX_STEP = 1'b0;

	// Divide by ten through a reciprocal; exact for every 16-bit input.
	localparam logic [16:0] DIV10_MUL = 17'd52429;
	localparam int DIV10_SHIFT = 19;
	localparam int DIV10_PW = HGT_W + 17;

	// Item as held in the input stage, with the range height already chosen.
	typedef struct packed {
		logic takeoff_phase;
		logic sensors_ready;
		logic flying;
		logic auto_takeoff_mode;
		logic range_hw_ok;
		logic range_valid;
		logic [HGT_W-1:0] range_h;
		logic signed [BARO_W-1:0] baro;
	} stage_t;

	// Result item.
	typedef struct packed {
		logic signed [REF_W-1:0] ref_height_cm;
		logic fusion_paused;
	} result_t;

	// Truncating divide by ten of a 16-bit value.
	function automatic logic [HGT_W-1:0] div10(input logic [HGT_W-1:0] v);
		logic [DIV10_PW-1:0] p;
		p = DIV10_PW'(v) * DIV10_PW'(DIV10_MUL);
		return HGT_W'(p >> DIV10_SHIFT);
	endfunction

endpackage

`default_nettype wire

@@ rtl/btrs_sample_if.sv @@
`default_nettype none

interface btrs_sample_if;
	logic valid;
	logic ready;
	logic takeoff_phase;
	logic sensors_ready;
	logic flying;
	logic auto_takeoff_mode;
	logic tof_hw_ok;
	logic flow_hw_ok;
	logic tof_valid;
	logic flow_tof_valid;
	logic [15:0] flow_height_cm;
	logic [15:0] tof_range_mm;
	logic signed [23:0] baro_height_cm;

	modport source (
		output valid, takeoff_phase, sensors_ready, flying, auto_takeoff_mode, tof_hw_ok,
			flow_hw_ok, tof_valid, flow_tof_valid, flow_height_cm, tof_range_mm,
			baro_height_cm,
		input ready
	);

	modport sink (
		input valid, takeoff_phase, sensors_ready, flying, auto_takeoff_mode, tof_hw_ok,
			flow_hw_ok, tof_valid, flow_tof_valid, flow_height_cm, tof_range_mm,
			baro_height_cm,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/btrs_result_if.sv @@
`default_nettype none

interface btrs_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] ref_height_cm;
	logic fusion_paused;

	modport source (
		output valid, ref_height_cm, fusion_paused,
		input ready
	);

	modport sink (
		input valid, ref_height_cm, fusion_paused,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/btrs_height_core.sv @@
`default_nettype none

module btrs_height_core (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  btrs_pkg::stage_t item,
	input  logic signed [btrs_pkg::FIX_W-1:0] fix_step,
	output btrs_pkg::result_t res
);
	import btrs_pkg::*;

	localparam logic [1:0] LS_CAPTURE = 2'd0;
	localparam logic [1:0] LS_CAPTURED = 2'd1;
	localparam logic [1:0] LS_TAKEOFF = 2'd2;

	logic [1:0] lock_q, lock_a, lock_n;
	logic [REF_W-1:0] zero_q, zero_n;
	logic [REF_W-1:0] corr_q, corr_n;
	logic [REF_W-1:0] rel_q, rel_n;
	logic locked_q, locked_n;
	logic [REF_W-1:0] b2t_q, b2t_n;
	logic [REF_W-1:0] t2b_q, t2b_n;
	logic [REF_W-1:0] last_q, last_n;
	logic active, paused;
	logic [REF_W-1:0] baro32, fix32, h32, g2, x;
	logic [REF_W+1:0] s, q;

	// Zero-offset lock machine and relative barometer height.
	always_comb begin
		lock_a = item.takeoff_phase ? LS_TAKEOFF :
			((lock_q == LS_TAKEOFF) ? LS_CAPTURE : lock_q);
		active = (lock_a != LS_CAPTURE);
		baro32 = {{(REF_W-BARO_W){item.baro[BARO_W-1]}}, item.baro};
		rel_n = active ? (baro32 - zero_q + corr_q + t2b_q) : rel_q;
		zero_n = active ? zero_q : baro32;
		lock_n = (!active && item.sensors_ready) ? LS_CAPTURED : lock_a;
	end

	// Correction term for the next item.
	always_comb begin
		paused = !item.flying && item.auto_takeoff_mode;
		fix32 = {{(REF_W-FIX_W){fix_step[FIX_W-1]}}, fix_step};
		corr_n = paused ? '0 : (REF_W'(0) - {fix32[REF_W-2:0], 1'b0});
	end

	// Reverse offset follows halfway, truncated toward zero.
	always_comb begin
		h32 = {{(REF_W-HGT_W){1'b0}}, item.range_h};
		g2 = h32 + b2t_q;
		x = g2 - rel_n - t2b_q;
		s = {t2b_q[REF_W-1], t2b_q, 1'b0} + {{2{x[REF_W-1]}}, x};
		q = {s[REF_W+1], s[REF_W+1:1]} + (REF_W+2)'(s[REF_W+1] & s[0]);
	end

	// Reference selection between barometer and range source.
	always_comb begin
		locked_n = locked_q;
		b2t_n = b2t_q;
		t2b_n = t2b_q;
		last_n = rel_n;
		if (item.range_hw_ok && lock_n != LS_CAPTURE) begin
			if (item.range_valid) begin
				if (locked_q) begin
					last_n = g2;
					t2b_n = q[REF_W-1:0];
				end else begin
					b2t_n = rel_n - h32;
					locked_n = 1'b1;
					last_n = last_q;
				end
			end else begin
				locked_n = 1'b0;
			end
		end
		res.ref_height_cm = last_n;
		res.fusion_paused = paused;
	end

	// State registers advance once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= LS_CAPTURE;
			zero_q <= '0;
			corr_q <= '0;
			rel_q <= '0;
			locked_q <= 1'b0;
			b2t_q <= '0;
			t2b_q <= '0;
			last_q <= '0;
		end else if (adv) begin
			lock_q <= lock_n;
			zero_q <= zero_n;
			corr_q <= corr_n;
			rel_q <= rel_n;
			locked_q <= locked_n;
			b2t_q <= b2t_n;
			t2b_q <= t2b_n;
			last_q <= last_n;
		end
	end

endmodule

`default_nettype wire

@@ rtl/baro_tof_height_reference_switch.sv @@
// A result is valid once its item has moved from the input stage into the
// result register. Throughput: one item per cycle while the result side does
// not stall; the state update of an item is combinational between the two.
// Reset (arst_n low) clears all height state, the lock machine and the
// correction register; the input stage is left empty and ready for an item.
`default_nettype none

module baro_tof_height_reference_switch (
	input  logic clk,
	input  logic arst_n,
	btrs_sample_if.sink sample,
	btrs_result_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [btrs_pkg::ADDR_W-1:0] paddr,
	input  logic [btrs_pkg::DATA_W-1:0] pwdata,
	output logic [btrs_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import btrs_pkg::*;

	logic signed [FIX_W-1:0] fix_q;
	logic fix_sel;
	logic s1_vld_q, out_vld_q;
	stage_t s1_item, in_item;
	result_t out_res_q, core_res;
	logic out_free, adv, in_acc;

	// Configuration register.
	assign pready = 1'b1;
	assign fix_sel = (paddr[ADDR_W-1:2] == REG_BARO_FIX_STEP);
	assign prdata = fix_sel ? {{(DATA_W-FIX_W){fix_q[FIX_W-1]}}, fix_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_q <= '0;
		end else if (psel && penable && pwrite && fix_sel) begin
			fix_q <= pwdata[FIX_W-1:0];
		end
	end

	// Item pick-up: range source chosen and scaled before the input stage.
	always_comb begin
		in_item.takeoff_phase = sample.takeoff_phase;
		in_item.sensors_ready = sample.sensors_ready;
		in_item.flying = sample.flying;
		in_item.auto_takeoff_mode = sample.auto_takeoff_mode;
		in_item.range_hw_ok = sample.tof_hw_ok || sample.flow_hw_ok;
		in_item.range_valid = sample.tof_valid || sample.flow_tof_valid;
		in_item.range_h = sample.flow_tof_valid ? sample.flow_height_cm :
			div10(sample.tof_range_mm);
		in_item.baro = sample.baro_height_cm;
	end

	// Handshake: the result register parts the two sides.
	assign out_free = !out_vld_q || result.ready;
	assign adv = s1_vld_q && out_free;
	assign sample.ready = !s1_vld_q || adv;
	assign in_acc = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_vld_q <= 1'b1;
			end else if (adv) begin
				s1_vld_q <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_item <= in_item;
		end
		if (adv) begin
			out_res_q <= core_res;
		end
	end

	btrs_height_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.item(s1_item),
		.fix_step(fix_q),
		.res(core_res)
	);

	assign result.valid = out_vld_q;
	assign result.ref_height_cm = out_res_q.ref_height_cm;
	assign result.fusion_paused = out_res_q.fusion_paused;

	// An item leaving the input stage always lands in the result register.
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_vld_q)
		else $error("item left the input stage without a result");

	// Both stages full and the output stalled: no new item may enter.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && out_vld_q && !result.ready) |-> !sample.ready)
		else $error("item accepted while both stages are held");

	// An empty input stage always takes an item.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_vld_q |-> sample.ready)
		else $error("empty input stage refuses an item");

endmodule

`default_nettype wire

@@ dv/baro_tof_height_reference_switch_tb.sv @@
`default_nettype none

module baro_tof_height_reference_switch_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import btrs_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PER_PHASE = 410;
	localparam int FIX_LOW = -1000;
	localparam int FIX_HIGH = 1000;

	// Barometer zero lock states, as the block tracks them.
	typedef enum logic [1:0] {
		LOCK_CAPTURE = 2'd0,
		LOCK_HELD = 2'd1,
		LOCK_TAKEOFF = 2'd2
	} lock_state_t;

	typedef struct {
		bit takeoff_phase;
		bit sensors_ready;
		bit flying;
		bit auto_takeoff_mode;
		bit tof_hw_ok;
		bit flow_hw_ok;
		bit tof_valid;
		bit flow_tof_valid;
		bit [HGT_W-1:0] flow_height_cm;
		bit [HGT_W-1:0] tof_range_mm;
		bit signed [BARO_W-1:0] baro_height_cm;
	} baro_item_t;

	typedef struct {
		logic signed [REF_W-1:0] ref_height_cm;
		bit fusion_paused;
	} height_result_t;

	typedef struct {
		baro_item_t item;
		bit has_exp;
		logic signed [REF_W-1:0] exp_ref;
		bit exp_paused;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	btrs_sample_if sample ();
	btrs_result_if result ();

	baro_tof_height_reference_switch dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample.sink),
		.result(result.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Height state mirrored from the block.
	logic signed [FIX_W-1:0] fix_step;
	lock_state_t lock_state;
	logic [31:0] baro_zero;
	logic [31:0] baro_corr;
	logic [31:0] baro_rel;
	bit tof_locked;
	logic [31:0] baro_to_tof;
	logic [31:0] tof_to_baro;
	logic [31:0] last_ref;

	height_result_t height_q[$];
	int n_taken;
	int idle_cycles;
	int n_errors;
	int send_idle_pct;
	int recv_idle_pct;
	bit next_has_exp;
	height_result_t next_exp;
	directed_row_t dir_rows[20];

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Works out the reference height and pause flag for one item.
	function automatic height_result_t predict_height(input baro_item_t it);
		height_result_t r;
		logic [31:0] baro;
		logic [31:0] h;
		logic [31:0] g2;
		logic [31:0] x;
		longint s;
		bit paused;

		baro = 32'(it.baro_height_cm);
		if (it.takeoff_phase) begin
			lock_state = LOCK_TAKEOFF;
		end else if (lock_state == LOCK_TAKEOFF) begin
			lock_state = LOCK_CAPTURE;
		end

		if (lock_state != LOCK_CAPTURE) begin
			baro_rel = baro - baro_zero + baro_corr + tof_to_baro;
		end else begin
			baro_zero = baro;
			if (it.sensors_ready)
				lock_state = LOCK_HELD;
		end

		// The correction taken here is only used on the next item.
		paused = !it.flying && it.auto_takeoff_mode;
		baro_corr = paused ? 32'd0 : 32'd0 - 32'(2 * int'(fix_step));

		if ((it.tof_hw_ok || it.flow_hw_ok) && lock_state != LOCK_CAPTURE) begin
			if (it.tof_valid || it.flow_tof_valid) begin
				h = it.flow_tof_valid ? 32'(it.flow_height_cm) : 32'(it.tof_range_mm / 10);
				if (tof_locked) begin
					g2 = h + baro_to_tof;
					x = (g2 - baro_rel) - tof_to_baro;
					s = 2 * longint'($signed(tof_to_baro)) + longint'($signed(x));
					last_ref = g2;
					tof_to_baro = 32'(s / 2);
				end else begin
					baro_to_tof = baro_rel - h;
					tof_locked = 1'b1;
				end
			end else begin
				tof_locked = 1'b0;
				last_ref = baro_rel;
			end
		end else begin
			last_ref = baro_rel;
		end

		r.ref_height_cm = last_ref;
		r.fusion_paused = paused;
		return r;
	endfunction

	// Receiver side: ready drops at random, one decision per falling edge.
	always @(negedge clk) begin
		if (arst_n)
			result.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Both handshakes are observed here, input first, in one process.
	always @(posedge clk) begin
		baro_item_t it;
		height_result_t pred;
		height_result_t want;
		bit moved;

		if (arst_n) begin
			moved = 1'b0;
			if (sample.valid && sample.ready) begin
				it.takeoff_phase = sample.takeoff_phase;
				it.sensors_ready = sample.sensors_ready;
				it.flying = sample.flying;
				it.auto_takeoff_mode = sample.auto_takeoff_mode;
				it.tof_hw_ok = sample.tof_hw_ok;
				it.flow_hw_ok = sample.flow_hw_ok;
				it.tof_valid = sample.tof_valid;
				it.flow_tof_valid = sample.flow_tof_valid;
				it.flow_height_cm = sample.flow_height_cm;
				it.tof_range_mm = sample.tof_range_mm;
				it.baro_height_cm = sample.baro_height_cm;
				pred = predict_height(it);
				height_q.push_back(next_has_exp ? next_exp : pred);
				n_taken++;
				moved = 1'b1;
			end
			if (result.valid && result.ready) begin
				moved = 1'b1;
				if (height_q.size() == 0) begin
					$error("result item with no expectation waiting");
					n_errors++;
				end else begin
					want = height_q.pop_front();
					if (result.ref_height_cm !== want.ref_height_cm) begin
						$error("ref_height_cm: expected %0d, got %0d",
							want.ref_height_cm, result.ref_height_cm);
						n_errors++;
					end
					if (result.fusion_paused !== want.fusion_paused) begin
						$error("fusion_paused: expected %0d, got %0d",
							want.fusion_paused, result.fusion_paused);
						n_errors++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog on cycles with no handshake.
	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// Presents one item and waits until it is taken.
	task automatic send_item(input baro_item_t it);
		int target;

		while ($urandom_range(99) < send_idle_pct) begin
			sample.valid = 1'b0;
			@(negedge clk);
		end
		sample.takeoff_phase = it.takeoff_phase;
		sample.sensors_ready = it.sensors_ready;
		sample.flying = it.flying;
		sample.auto_takeoff_mode = it.auto_takeoff_mode;
		sample.tof_hw_ok = it.tof_hw_ok;
		sample.flow_hw_ok = it.flow_hw_ok;
		sample.tof_valid = it.tof_valid;
		sample.flow_tof_valid = it.flow_tof_valid;
		sample.flow_height_cm = it.flow_height_cm;
		sample.tof_range_mm = it.tof_range_mm;
		sample.baro_height_cm = it.baro_height_cm;
		sample.valid = 1'b1;
		target = n_taken + 1;
		do @(negedge clk); while (n_taken < target);
	endtask

	// Holds the sender until every expected result has come back.
	task automatic drain_heights();
		sample.valid = 1'b0;
		while (height_q.size() != 0)
			@(negedge clk);
	endtask

	// Writes the correction step once the block has gone quiet.
	task automatic write_fix_step(input int value);
		drain_heights();
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {REG_BARO_FIX_STEP, 2'b00};
		pwdata = DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		fix_step = FIX_W'(value);
	endtask

	// Random items: mostly plausible flight sequences with sticky range validity.
	task automatic run_random(input int count);
		baro_item_t it;
		int baro_walk;
		bit range_on;

		baro_walk = 0;
		range_on = 1'b0;
		for (int i = 0; i < count; i++) begin
			it.takeoff_phase = ($urandom_range(99) < 8);
			it.sensors_ready = ($urandom_range(99) < 80);
			it.flying = 1'($urandom_range(1));
			it.auto_takeoff_mode = 1'($urandom_range(1));
			it.tof_hw_ok = ($urandom_range(99) < 70);
			it.flow_hw_ok = ($urandom_range(99) < 50);
			if ($urandom_range(99) < 15)
				range_on = ~range_on;
			it.tof_valid = range_on && ($urandom_range(99) < 85);
			it.flow_tof_valid = range_on && ($urandom_range(99) < 35);
			if ($urandom_range(99) < 80) begin
				it.flow_height_cm = HGT_W'($urandom_range(3000));
				it.tof_range_mm = HGT_W'($urandom_range(30000));
			end else begin
				it.flow_height_cm = HGT_W'($urandom);
				it.tof_range_mm = HGT_W'($urandom);
			end
			if ($urandom_range(99) < 85)
				baro_walk = baro_walk + int'($urandom_range(400)) - 200;
			else
				baro_walk = int'($signed(BARO_W'($urandom)));
			it.baro_height_cm = BARO_W'(baro_walk);
			send_item(it);
			if (i == count / 2 && $urandom_range(1))
				drain_heights();
		end
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample.valid = 1'b0;
		sample.takeoff_phase = 1'b0;
		sample.sensors_ready = 1'b0;
		sample.flying = 1'b0;
		sample.auto_takeoff_mode = 1'b0;
		sample.tof_hw_ok = 1'b0;
		sample.flow_hw_ok = 1'b0;
		sample.tof_valid = 1'b0;
		sample.flow_tof_valid = 1'b0;
		sample.flow_height_cm = '0;
		sample.tof_range_mm = '0;
		sample.baro_height_cm = '0;
		result.ready = 1'b0;
		fix_step = '0;
		lock_state = LOCK_CAPTURE;
		baro_zero = '0;
		baro_corr = '0;
		baro_rel = '0;
		tof_locked = 1'b0;
		baro_to_tof = '0;
		tof_to_baro = '0;
		last_ref = '0;
		n_taken = 0;
		idle_cycles = 0;
		n_errors = 0;
		next_has_exp = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 56;

		// Directed items. Flags: takeoff, sensor ok, flying, auto, tof hw, flow hw,
		// tof valid, flow valid; then flow cm, tof mm, baro cm.
		// Capture from reset: the reference holds zero until the zero locks.
		dir_rows[0] = '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h7FFFFF}, 1, 0, 0};
		dir_rows[1] = '{'{0, 0, 0, 1, 0, 0, 0, 0, 65535, 65535, 24'h800000}, 1, 0, 1};
		// Zero locks and the first range reading only takes the switch offset.
		dir_rows[2] = '{'{0, 1, 0, 0, 1, 0, 1, 0, 0, 65535, 0}, 1, 0, 0};
		// Locked on time of flight, then the flow range takes priority.
		dir_rows[3] = '{'{0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 100}, 0, 0, 0};
		dir_rows[4] = '{'{0, 0, 1, 0, 0, 1, 1, 1, 65535, 12345, -50}, 0, 0, 0};
		// Range lost: unlock and fall back to the barometer.
		dir_rows[5] = '{'{0, 0, 1, 1, 0, 1, 0, 0, 0, 0, 300}, 0, 0, 0};
		// Relock, with mm values just under and over a tens boundary.
		dir_rows[6] = '{'{0, 0, 1, 1, 1, 0, 1, 0, 0, 9, 300}, 0, 0, 0};
		dir_rows[7] = '{'{0, 0, 0, 0, 1, 0, 1, 0, 0, 19, 310}, 0, 0, 0};
		dir_rows[8] = '{'{0, 0, 0, 0, 1, 1, 1, 1, 0, 10, 280}, 0, 0, 0};
		// Takeoff phase, then the fall back to capture.
		dir_rows[9] = '{'{1, 0, 0, 0, 1, 0, 1, 0, 0, 5000, 24'h7FFFFF}, 0, 0, 0};
		dir_rows[10] = '{'{1, 0, 1, 1, 0, 1, 0, 1, 1234, 0, 24'h7FFFFF}, 0, 0, 0};
		dir_rows[11] = '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h800000}, 0, 0, 0};
		// Still capturing: range readings are ignored until the zero locks again.
		dir_rows[12] = '{'{0, 0, 0, 0, 1, 0, 1, 0, 0, 777, 24'h800000}, 0, 0, 0};
		dir_rows[13] = '{'{0, 1, 0, 0, 1, 0, 1, 0, 0, 65535, 24'h800000}, 0, 0, 0};
		dir_rows[14] = '{'{0, 0, 1, 1, 1, 0, 1, 0, 0, 65534, 24'h800000}, 0, 0, 0};
		dir_rows[15] = '{'{0, 0, 0, 0, 0, 1, 0, 1, 65535, 0, -1}, 0, 0, 0};
		// No range hardware at all, then range hardware present again.
		dir_rows[16] = '{'{0, 0, 1, 0, 0, 0, 1, 1, 100, 100, 24'h7FFFFF}, 0, 0, 0};
		dir_rows[17] = '{'{0, 1, 0, 1, 1, 0, 0, 0, 0, 0, 5}, 0, 0, 0};
		dir_rows[18] = '{'{1, 1, 1, 1, 1, 1, 1, 1, 65535, 65535, -1}, 0, 0, 0};
		dir_rows[19] = '{'{0, 1, 1, 1, 1, 1, 1, 1, 65535, 65535, -1}, 0, 0, 0};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_fix_step(FIX_HIGH);
		foreach (dir_rows[i]) begin
			next_has_exp = dir_rows[i].has_exp;
			next_exp.ref_height_cm = dir_rows[i].exp_ref;
			next_exp.fusion_paused = dir_rows[i].exp_paused;
			send_item(dir_rows[i].item);
		end
		next_has_exp = 1'b0;

		// Sender seldom idle, receiver often stalled.
		write_fix_step(FIX_LOW);
		run_random(RANDOM_PER_PHASE);
		drain_heights();
		run_random(RANDOM_PER_PHASE / 4);

		// The other way round.
		write_fix_step($urandom_range(2 * FIX_HIGH) + FIX_LOW);
		send_idle_pct = 56;
		recv_idle_pct = 11;
		run_random(RANDOM_PER_PHASE);

		// Full rate on both sides.
		write_fix_step($urandom_range(2 * FIX_HIGH) + FIX_LOW);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(RANDOM_PER_PHASE);

		drain_heights();
		repeat (SETTLE_CYCLES * 2) @(negedge clk);
		if (n_errors == 0 && height_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
